FILE: rtl/ssq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package ssq_pkg;

    // Queue geometry and field widths
    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int VALUE_BITS    = 32;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [PRIORITY_BITS-1:0]     t_prio;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    // One stored entry
    typedef struct packed {
        t_value value;
        t_prio  prio;
    } t_entry;

    // Input item
    typedef struct packed {
        logic   kind;
        t_value value;
        t_prio  priority_req;
    } t_item;

    // Result item
    typedef struct packed {
        t_value     front_value;
        t_value     back_value;
        t_cnt       entry_count;
        logic       is_empty;
        logic [1:0] status;
    } t_result;

    // Map a position in queue order to a RAM address of the circular buffer
    function automatic t_idx phys_addr(input t_idx head, input t_idx pos);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: sequencer, head/tail tracking, results.
// Depends on ssq_pkg and ssq_ram.
`timescale 1ns / 1ps

// Entries sit in one RAM used as a circular buffer in priority order (ties in arrival
// order). An item is taken when start is high and busy is low; its result appears on
// o_result for exactly one cycle with o_strobe, and the receiver cannot stall it.
// A pop is done without leaving idle when it empties the queue or hits an empty queue;
// otherwise it makes one RAM read for the new head. A push into an empty or full queue
// is done without leaving idle; otherwise each stored entry with a larger priority
// number is moved one slot back by a read-then-write walk from the tail, one entry per
// cycle through the single read and write ports. The strobe is registered and comes in
// the cycle after the item finishes, and the next item may start in that cycle.
module stable_sorted_priority_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ssq_pkg::t_item   i_item,
    output logic             o_strobe,
    output ssq_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_PLACE = 4'b0100,
        S_POPWT = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    ssq_pkg::t_idx     r_head, n_head;
    ssq_pkg::t_cnt     r_count, n_count;
    ssq_pkg::t_idx     r_slot, n_slot;
    ssq_pkg::t_value   r_front, n_front;
    ssq_pkg::t_value   r_back, n_back;
    ssq_pkg::t_entry   r_new, n_new;
    logic [1:0]        r_status, n_status;
    logic              r_done, n_done;

    logic              ram_we, ram_re;
    ssq_pkg::t_idx     ram_waddr, ram_raddr;
    ssq_pkg::t_entry   ram_wdata, ram_rdata;
    logic              accept;
    ssq_pkg::t_idx     slot_next;

    ssq_ram #(
        .DEPTH (ssq_pkg::QUEUE_DEPTH),
        .WIDTH ($bits(ssq_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign slot_next = r_slot + ssq_pkg::IDX_W'(1);

    // Sequence one item: pointer update, shift walk, head refetch.
    // The walk reads position p-1 while writing p+1, so a RAM entry is always read
    // before it is overwritten and no forwarding is needed.
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_slot    = r_slot;
        n_front   = r_front;
        n_back    = r_back;
        n_new     = r_new;
        n_status  = r_status;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_head;
        ram_raddr = r_head;
        ram_wdata = r_new;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.kind == ssq_pkg::KIND_POP) begin
                        n_status = ssq_pkg::ST_OK;
                        if (r_count == '0) begin
                            n_status = ssq_pkg::ST_POP_EMPTY;
                            n_done   = 1'b1;
                        end else begin
                            n_head  = ssq_pkg::phys_addr(r_head, ssq_pkg::IDX_W'(1));
                            n_count = r_count - ssq_pkg::CNT_W'(1);
                            if (r_count == ssq_pkg::CNT_W'(1)) begin
                                n_done = 1'b1;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = ssq_pkg::phys_addr(r_head, ssq_pkg::IDX_W'(1));
                                n_state   = S_POPWT;
                            end
                        end
                    end else begin
                        n_status  = ssq_pkg::ST_OK;
                        n_new     = '{value: i_item.value, prio: i_item.priority_req};
                        if (r_count == ssq_pkg::CNT_W'(ssq_pkg::QUEUE_DEPTH)) begin
                            n_status = ssq_pkg::ST_PUSH_FULL;
                            n_done   = 1'b1;
                        end else if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_head;
                            ram_wdata = '{value: i_item.value, prio: i_item.priority_req};
                            n_front   = i_item.value;
                            n_back    = i_item.value;
                            n_count   = ssq_pkg::CNT_W'(1);
                            n_done    = 1'b1;
                        end else begin
                            // Start the walk at the tail
                            n_slot    = ssq_pkg::IDX_W'(r_count - ssq_pkg::CNT_W'(1));
                            ram_re    = 1'b1;
                            ram_raddr = ssq_pkg::phys_addr(r_head,
                                ssq_pkg::IDX_W'(r_count - ssq_pkg::CNT_W'(1)));
                            n_state   = S_SHIFT;
                        end
                    end
                end
            end

            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = ssq_pkg::phys_addr(r_head, slot_next);
                if (ram_rdata.prio > r_new.prio) begin
                    // Move the entry one slot back and keep walking toward the head
                    ram_wdata = ram_rdata;
                    if (r_slot == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ssq_pkg::phys_addr(r_head,
                            r_slot - ssq_pkg::IDX_W'(1));
                        n_slot    = r_slot - ssq_pkg::IDX_W'(1);
                    end
                end else begin
                    // Drop the new entry behind every entry of lower or equal number
                    ram_wdata = r_new;
                    if (ssq_pkg::CNT_W'(slot_next) == r_count) begin
                        n_back = r_new.value;
                    end
                    n_count = r_count + ssq_pkg::CNT_W'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_PLACE: begin
                // New entry becomes the head
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = r_new;
                n_front   = r_new.value;
                n_count   = r_count + ssq_pkg::CNT_W'(1);
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end

            S_POPWT: begin
                // Capture the new head
                n_front = ram_rdata.value;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_slot   <= n_slot;
        r_front  <= n_front;
        r_back   <= n_back;
        r_new    <= n_new;
        r_status <= n_status;
    end

    // Present the result; an empty queue shows zero at both ends
    assign o_strobe             = r_done;
    assign o_result.front_value = (r_count == '0) ? '0 : r_front;
    assign o_result.back_value  = (r_count == '0) ? '0 : r_back;
    assign o_result.entry_count = r_count;
    assign o_result.is_empty    = (r_count == '0);
    assign o_result.status      = r_status;

    // The walk never reads and writes the same entry in one cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("entry RAM read and write hit the same address");

    // A result is shown only once the sequencer is back in idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while an item is still in work");

    // A dropped push reports a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ssq_pkg::ST_PUSH_FULL
        |-> r_count == ssq_pkg::CNT_W'(ssq_pkg::QUEUE_DEPTH))
        else $error("push-full status with room left");

    // The count grows by at most one per item and never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssq_pkg::CNT_W'(ssq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

endmodule

FILE: rtl/ssq_ram.sv
// Simple dual-port entry RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the stable sorted priority queue.
// Depends on ssq_pkg and stable_sorted_priority_queue from the rtl folder.
`timescale 1ns / 1ps

module testbench;
    import ssq_pkg::*;

    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 650;
    localparam int MAX_SHOWN  = 10;

    // One row of the directed table: the item, and a hand-written result where it is obvious
    typedef struct {
        t_item   op;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    // Hand-written expectation for the item currently presented
    bit      typed_ok;
    t_result typed_exp;

    // Shadow copy of the queue contents, kept in service order
    t_value  sorted_vals [QUEUE_DEPTH];
    t_prio   sorted_pris [QUEUE_DEPTH];
    int      held_count;

    t_result pending_results [$];
    int      mismatches;

    // Directed stimulus: empty pop, extremes, ties, fill to full, pushes on full, refill
    t_dir_row dir_tab [N_DIRECTED] = '{
        '{'{KIND_POP,  32'h1234_5678, 8'd77},  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ST_POP_EMPTY}},
        '{'{KIND_PUSH, 32'h7FFF_FFFF, 8'd0},   1'b1,
          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, ST_OK}},
        '{'{KIND_PUSH, 32'h8000_0000, 8'd255}, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 5'd2, 1'b0, ST_OK}},
        '{'{KIND_PUSH, 32'h0000_0005, 8'd0},   1'b0, '0},
        '{'{KIND_PUSH, 32'hFFFF_FFFF, 8'd128}, 1'b0, '0},
        '{'{KIND_PUSH, 32'hAAAA_AAAA, 8'd1},   1'b0, '0},
        '{'{KIND_PUSH, 32'h5555_5555, 8'd254}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h0000_0000, 8'd128}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h0000_0001, 8'd0},   1'b0, '0},
        '{'{KIND_PUSH, 32'h8000_0001, 8'd255}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h7FFF_FFFE, 8'd128}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h0F0F_0F0F, 8'd64},  1'b0, '0},
        '{'{KIND_PUSH, 32'hF0F0_F0F0, 8'd192}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h3333_3333, 8'd1},   1'b0, '0},
        '{'{KIND_PUSH, 32'hCCCC_CCCC, 8'd127}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h0000_00FF, 8'd129}, 1'b0, '0},
        '{'{KIND_PUSH, 32'hFFFF_FF00, 8'd0},   1'b0, '0},
        '{'{KIND_PUSH, 32'h1111_1111, 8'd0},   1'b0, '0},
        '{'{KIND_PUSH, 32'h2222_2222, 8'd255}, 1'b0, '0},
        '{'{KIND_POP,  32'hFFFF_FFFF, 8'd255}, 1'b0, '0},
        '{'{KIND_PUSH, 32'h4444_4444, 8'd0},   1'b0, '0},
        '{'{KIND_POP,  32'h0000_0000, 8'd0},   1'b0, '0}
    };

    stable_sorted_priority_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Apply one push or pop to the shadow queue and build the result it should report
    task automatic apply_queue_op(input t_item op, output t_result res);
        int         slot;
        logic [1:0] st;
        st = ST_OK;
        if (op.kind == KIND_POP) begin
            if (held_count == 0) begin
                st = ST_POP_EMPTY;
            end else begin
                for (int i = 0; i + 1 < held_count; i++) begin
                    sorted_vals[i] = sorted_vals[i+1];
                    sorted_pris[i] = sorted_pris[i+1];
                end
                held_count--;
            end
        end else if (held_count >= QUEUE_DEPTH) begin
            st = ST_PUSH_FULL;
        end else begin
            // Go behind every entry of lower or equal priority number
            slot = 0;
            while (slot < held_count && sorted_pris[slot] <= op.priority_req) begin
                slot++;
            end
            for (int i = held_count; i > slot; i--) begin
                sorted_vals[i] = sorted_vals[i-1];
                sorted_pris[i] = sorted_pris[i-1];
            end
            sorted_vals[slot] = op.value;
            sorted_pris[slot] = op.priority_req;
            held_count++;
        end
        res.front_value = (held_count > 0) ? sorted_vals[0] : '0;
        res.back_value  = (held_count > 0) ? sorted_vals[held_count-1] : '0;
        res.entry_count = t_cnt'(held_count);
        res.is_empty    = (held_count == 0);
        res.status      = st;
    endtask

    // Present one item from the falling edge and hold it until the transfer
    task automatic send_op(input t_item op, input bit has_typed, input t_result typed);
        start     = 1'b1;
        i_item    = op;
        typed_ok  = has_typed;
        typed_exp = typed;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // Now and then drop start for a random idle gap
    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 9) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // Check results and record expectations at each rising edge
    always @(posedge i_clk) begin
        t_result exp_res;
        t_result pred;
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("[%0t] result with nothing pending: %p", $realtime, o_result);
                    end
                end else begin
                    exp_res = pending_results.pop_front();
                    if (o_result.front_value !== exp_res.front_value ||
                        o_result.back_value  !== exp_res.back_value  ||
                        o_result.entry_count !== exp_res.entry_count ||
                        o_result.is_empty    !== exp_res.is_empty    ||
                        o_result.status      !== exp_res.status) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("[%0t] mismatch: front %0d/%0d back %0d/%0d count %0d/%0d",
                                     $realtime, exp_res.front_value, o_result.front_value,
                                     exp_res.back_value, o_result.back_value,
                                     exp_res.entry_count, o_result.entry_count);
                            $display("    empty %0b/%0b status %0d/%0d (expected/actual)",
                                     exp_res.is_empty, o_result.is_empty,
                                     exp_res.status, o_result.status);
                        end
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                apply_queue_op(i_item, pred);
                pending_results.push_back(typed_ok ? typed_exp : pred);
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        t_item op;
        int    phase_left;
        int    push_pct;
        int    drain_wait;
        start      = 1'b0;
        i_item     = '0;
        typed_ok   = 1'b0;
        typed_exp  = '0;
        held_count = 0;
        mismatches = 0;
        phase_left = 0;
        push_pct   = 50;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_tab[r]) begin
            send_op(dir_tab[r].op, dir_tab[r].typed, dir_tab[r].res);
            maybe_idle(1'b1);
        end

        // Random phases that fill, drain or churn the queue
        for (int n = 0; n < N_RANDOM; n++) begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                phase_left = $urandom_range(10, 40);
            end
            phase_left--;
            op.kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            case ($urandom_range(0, 9))
                0: op.value = 32'h7FFF_FFFF;
                1: op.value = 32'h8000_0000;
                default: op.value = $urandom;
            endcase
            // Favor a few priorities so ties are common
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op.priority_req = t_prio'($urandom_range(0, 3));
                4: op.priority_req = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                default: op.priority_req = t_prio'($urandom_range(0, 255));
            endcase
            send_op(op, 1'b0, '0);
            // Keep a long stretch with back-to-back transfers
            maybe_idle(n < 250 || n >= 400);
        end
        start = 1'b0;

        // Drain outstanding results, then let the block settle
        drain_wait = 0;
        while (pending_results.size() > 0 && drain_wait < 2000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (25) @(posedge i_clk);
        if (pending_results.size() > 0) begin
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/ssq_pkg.sv
rtl/ssq_ram.sv
rtl/stable_sorted_priority_queue.sv
dv/testbench.sv
